[hdl/srcl_pkg.sv]
// Shared types and constants for the shift register config loader.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package srcl_pkg;

	localparam int NUM_DELAY_REGS_DEF = 8;
	localparam int REG_BITS_DEF       = 8;

	// Depth of the job queue between front and back (power of two).
	localparam int QDEPTH = 2;

	// Command codes
	localparam logic [1:0] CMD_SET_DELAY = 2'd0;
	localparam logic [1:0] CMD_GET_DELAY = 2'd1;
	localparam logic [1:0] CMD_SET_MUX   = 2'd2;
	localparam logic [1:0] CMD_GET_MUX   = 2'd3;

	// Job kinds handed from front to back
	localparam logic [1:0] JOB_SINGLE = 2'd0;
	localparam logic [1:0] JOB_DELAY  = 2'd1;
	localparam logic [1:0] JOB_MUX    = 2'd2;

	localparam logic [1:0] MUX_FIELD_MASK = 2'h3;
	localparam logic [7:0] STROBE_IDLE    = 8'hff;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] target_index;
		logic [7:0] write_value;
	} req_t;

	typedef struct packed {
		logic       shift_data_pin;
		logic       delay_clock_pin;
		logic       mux_clock_pin;
		logic [7:0] strobe_pins;
		logic [7:0] read_value;
		logic       last_update;
	} rsp_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] target;
		logic [7:0] read_value;
	} job_t;

	typedef struct packed {
		logic       data;
		logic       dclk;
		logic       mclk;
		logic [7:0] stb;
	} pins_t;

	localparam pins_t PINS_RESET = '{data: 1'b0, dclk: 1'b1, mclk: 1'b1, stb: STROBE_IDLE};

endpackage

`default_nettype wire

[hdl/srcl_front.sv]
// Front end: holds the delay and mux shadows, classifies each command
// and turns it into a job for the back end. Depends on srcl_pkg.
`default_nettype none

module srcl_front import srcl_pkg::*; #(
	parameter int NUM_DELAY_REGS = NUM_DELAY_REGS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire req_t req,
	output job_t      job
);

	localparam int DLY_IDX_W = (NUM_DELAY_REGS > 1) ? $clog2(NUM_DELAY_REGS) : 1;

	logic [7:0] delay_q [NUM_DELAY_REGS];
	logic [7:0] mux_q;

	logic                 dly_ok;
	logic                 mux_ok;
	logic [DLY_IDX_W-1:0] dly_idx;
	logic [2:0]           base;
	logic [7:0]           mux_next;
	logic [7:0]           dly_rd;

	always_comb begin
		dly_ok   = {1'b0, req.target_index} < 4'(NUM_DELAY_REGS);
		mux_ok   = ~req.target_index[2];
		dly_idx  = DLY_IDX_W'(req.target_index);
		base     = {req.target_index[1:0], 1'b0};
		mux_next = (mux_q & ~(8'(MUX_FIELD_MASK) << base)) |
			(8'(req.write_value[1:0] & MUX_FIELD_MASK) << base);
		dly_rd   = dly_ok ? delay_q[dly_idx] : 8'd0;
	end

	always_comb begin
		job = '{kind: JOB_SINGLE, value: 8'd0, target: req.target_index, read_value: 8'd0};
		case (req.command)
			CMD_SET_DELAY: begin
				if (dly_ok) begin
					job.kind  = JOB_DELAY;
					job.value = req.write_value;
				end
			end
			CMD_GET_DELAY: begin
				job.read_value = dly_rd;
			end
			CMD_SET_MUX: begin
				if (mux_ok) begin
					job.kind  = JOB_MUX;
					job.value = mux_next;
				end
			end
			CMD_GET_MUX: begin
				if (mux_ok)
					job.read_value = 8'((mux_q >> base) & 8'(MUX_FIELD_MASK));
			end
			default: begin
				job.kind = JOB_SINGLE;
			end
		endcase
	end

	// Shadows update at accept so later reads see them in command order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_q <= 8'd0;
			for (int i = 0; i < NUM_DELAY_REGS; i++)
				delay_q[i] <= 8'd0;
		end else if (accept) begin
			if (req.command == CMD_SET_DELAY && dly_ok)
				delay_q[dly_idx] <= req.write_value;
			if (req.command == CMD_SET_MUX && mux_ok)
				mux_q <= mux_next;
		end
	end

endmodule

`default_nettype wire

[hdl/srcl_queue.sv]
// Short job queue between front and back end, register based.
// Depends on srcl_pkg for job_t and QDEPTH.
`default_nettype none

module srcl_queue import srcl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head,
	output logic      empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/srcl_back.sv]
// Back end: pin sequencer that plays one job at a time, one pin update per
// cycle while in a job, and registers each result word. Depends on srcl_pkg.
`default_nettype none

module srcl_back import srcl_pkg::*; #(
	parameter int REG_BITS = REG_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic empty,
	input  wire job_t head,
	output logic      pop,
	output rsp_t      rsp,
	output logic      rsp_strobe
);

	localparam int BIT_W = (REG_BITS > 1) ? $clog2(REG_BITS) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SINGLE = 3'd1;
	localparam logic [2:0] S_DATA   = 3'd2;
	localparam logic [2:0] S_CLKLO  = 3'd3;
	localparam logic [2:0] S_CLKHI  = 3'd4;
	localparam logic [2:0] S_STBLO  = 3'd5;
	localparam logic [2:0] S_STBHI  = 3'd6;

	logic [2:0]       state_q, state_n;
	logic [BIT_W-1:0] bit_q, bit_n;
	job_t             job_q, job_n;
	pins_t            pin_q, pin_n;
	rsp_t             rsp_q;
	logic             strobe_q;

	logic                emit;
	logic                last;
	logic [7:0]          rd;
	logic [REG_BITS-1:0] ext_val;

	// Bits above the 8-bit value go out as zero.
	assign ext_val = REG_BITS'(job_q.value);

	always_comb begin
		state_n = state_q;
		bit_n   = bit_q;
		job_n   = job_q;
		pin_n   = pin_q;
		pop     = 1'b0;
		emit    = 1'b0;
		last    = 1'b0;
		rd      = 8'd0;
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					job_n   = head;
					bit_n   = BIT_W'(REG_BITS - 1);
					state_n = (head.kind == JOB_SINGLE) ? S_SINGLE : S_DATA;
				end
			end
			S_SINGLE: begin
				emit    = 1'b1;
				last    = 1'b1;
				rd      = job_q.read_value;
				state_n = S_IDLE;
			end
			S_DATA: begin
				emit       = 1'b1;
				pin_n.data = ext_val[bit_q];
				state_n    = S_CLKLO;
			end
			S_CLKLO: begin
				emit = 1'b1;
				if (job_q.kind == JOB_DELAY)
					pin_n.dclk = 1'b0;
				else
					pin_n.mclk = 1'b0;
				state_n = S_CLKHI;
			end
			S_CLKHI: begin
				emit = 1'b1;
				if (job_q.kind == JOB_DELAY)
					pin_n.dclk = 1'b1;
				else
					pin_n.mclk = 1'b1;
				if (bit_q == '0) begin
					if (job_q.kind == JOB_DELAY) begin
						state_n = S_STBLO;
					end else begin
						last    = 1'b1;
						state_n = S_IDLE;
					end
				end else begin
					bit_n   = bit_q - 1'b1;
					state_n = S_DATA;
				end
			end
			S_STBLO: begin
				emit                    = 1'b1;
				pin_n.stb[job_q.target] = 1'b0;
				state_n                 = S_STBHI;
			end
			S_STBHI: begin
				emit                    = 1'b1;
				last                    = 1'b1;
				pin_n.stb[job_q.target] = 1'b1;
				state_n                 = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bit_q    <= '0;
			pin_q    <= PINS_RESET;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			bit_q    <= bit_n;
			pin_q    <= pin_n;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		job_q <= job_n;
		rsp_q <= '{shift_data_pin: pin_n.data, delay_clock_pin: pin_n.dclk,
			mux_clock_pin: pin_n.mclk, strobe_pins: pin_n.stb,
			read_value: rd, last_update: last};
	end

	assign rsp        = rsp_q;
	assign rsp_strobe = strobe_q;

endmodule

`default_nettype wire

[hdl/shift_register_config_loader.sv]
// Top level of the shift register config loader: front end, job queue
// and pin sequencer. Depends on srcl_pkg, srcl_front, srcl_queue, srcl_back.
//
// Commands enter on start while busy is low and land in a two-deep job
// queue, so busy only rises when two commands are still waiting. The pin
// sequencer plays one job at a time and puts out one result word per cycle
// on rsp while playing a job, marked by rsp_strobe; the receiver cannot
// stall it and must take every word in the cycle it appears. A delay write
// loads its job, shifts REG_BITS bits out MSB first and pulses its strobe;
// a mux write shifts on the mux clock without a strobe, and a read or an
// ignored write gives one word. The sequencer's one pin update per cycle
// sets the rate; last_update marks the final word of each command. Shadow
// writes take effect at accept, so reads always see earlier writes.
`default_nettype none

module shift_register_config_loader import srcl_pkg::*; #(
	parameter int NUM_DELAY_REGS = NUM_DELAY_REGS_DEF,
	parameter int REG_BITS       = REG_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output rsp_t      rsp,
	output logic      rsp_strobe
);

	logic accept;
	job_t front_job;
	job_t head;
	logic full;
	logic empty;
	logic pop;

	assign accept = start & ~full;
	assign busy   = full;

	srcl_front #(.NUM_DELAY_REGS(NUM_DELAY_REGS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.job    (front_job)
	);

	srcl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (front_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	srcl_back #(.REG_BITS(REG_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp),
		.rsp_strobe (rsp_strobe)
	);

	// At most one strobe low at a time.
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe |-> $countones(~rsp.strobe_pins) <= 1)
		else $error("more than one latch strobe low");

	// Never clock both chains at once.
	a_one_clock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe |-> (rsp.delay_clock_pin || rsp.mux_clock_pin))
		else $error("both shift clocks low");

	// A strobe pulse only happens with both clocks parked high.
	a_strobe_clk: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_strobe && rsp.strobe_pins != STROBE_IDLE) |->
		(rsp.delay_clock_pin && rsp.mux_clock_pin))
		else $error("strobe low while a shift clock is low");

	// Read data only appears on a single-word reply.
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_strobe && rsp.read_value != 8'd0) |-> rsp.last_update)
		else $error("read value on a word that is not last");

endmodule

`default_nettype wire

[dv/shift_register_config_loader_test.sv]
// Self-checking testbench for shift_register_config_loader: a queue-fed driver
// and a monitor that checks every pin update word against a local predictor.
// Depends on srcl_pkg and the RTL in hdl/.
module shift_register_config_loader_test;
	import srcl_pkg::*;

	localparam int STALL_LIMIT = 500;
	localparam int DRAIN_CYCLES = 40;
	localparam int TAIL_ITEMS = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	rsp_t rsp;
	logic rsp_strobe;

	shift_register_config_loader u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp(rsp),
		.rsp_strobe(rsp_strobe)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [7:0] mux_mirror = '0;
	logic [7:0] delay_mirror [NUM_DELAY_REGS_DEF];
	pins_t model_pins = PINS_RESET;

	req_t pending_cmds [$];
	rsp_t expected_updates [$];
	int n_issued = 0;
	int n_accepted = 0;
	int gap_left = 0;
	int stall_cycles = 0;
	int errors = 0;
	int words_checked = 0;
	int cmd_seen [4] = '{0, 0, 0, 0};

	initial begin
		for (int i = 0; i < NUM_DELAY_REGS_DEF; i++)
			delay_mirror[i] = '0;
	end

	function automatic void post_word(input logic [7:0] rd, input logic last);
		rsp_t w;
		w.shift_data_pin = model_pins.data;
		w.delay_clock_pin = model_pins.dclk;
		w.mux_clock_pin = model_pins.mclk;
		w.strobe_pins = model_pins.stb;
		w.read_value = rd;
		w.last_update = last;
		expected_updates.push_back(w);
	endfunction

	// MSB first: data, clock low, clock high per bit
	function automatic void shift_value(input logic [7:0] value, input logic on_mux,
			input logic ends_cmd);
		for (int i = REG_BITS_DEF - 1; i >= 0; i--) begin
			model_pins.data = (i < 8) ? value[i % 8] : 1'b0;
			post_word('0, 1'b0);
			if (on_mux)
				model_pins.mclk = 1'b0;
			else
				model_pins.dclk = 1'b0;
			post_word('0, 1'b0);
			if (on_mux)
				model_pins.mclk = 1'b1;
			else
				model_pins.dclk = 1'b1;
			post_word('0, ends_cmd && i == 0);
		end
	endfunction

	function automatic void apply_command(input req_t c);
		int idx;
		logic [7:0] m;
		idx = c.target_index;
		case (c.command)
			CMD_SET_DELAY: begin
				if (idx < NUM_DELAY_REGS_DEF) begin
					delay_mirror[idx] = c.write_value;
					shift_value(c.write_value, 1'b0, 1'b0);
					model_pins.stb[idx] = 1'b0;
					post_word('0, 1'b0);
					model_pins.stb[idx] = 1'b1;
					post_word('0, 1'b1);
				end else begin
					post_word('0, 1'b1);
				end
			end
			CMD_GET_DELAY: begin
				post_word((idx < NUM_DELAY_REGS_DEF) ? delay_mirror[idx] : 8'h00, 1'b1);
			end
			CMD_SET_MUX: begin
				if (idx < 4) begin
					m = mux_mirror;
					m[idx * 2 +: 2] = c.write_value[1:0] & MUX_FIELD_MASK;
					mux_mirror = m;
					shift_value(mux_mirror, 1'b1, 1'b1);
				end else begin
					post_word('0, 1'b1);
				end
			end
			default: begin
				if (idx < 4)
					post_word({6'b0, mux_mirror[idx * 2 +: 2]}, 1'b1);
				else
					post_word('0, 1'b1);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	function automatic void queue_cmd(input logic [1:0] cmd, input logic [2:0] idx,
			input logic [7:0] val);
		req_t c;
		c.command = cmd;
		c.target_index = idx;
		c.write_value = val;
		pending_cmds.push_back(c);
	endfunction

	function automatic req_t random_cmd();
		req_t c;
		c.command = 2'($urandom_range(0, 3));
		if (c.command == CMD_SET_MUX || c.command == CMD_GET_MUX)
			c.target_index = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
				: 3'($urandom_range(4, 7));
		else
			c.target_index = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: c.write_value = 8'h00;
			1: c.write_value = 8'hff;
			default: c.write_value = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	// driver: hold a word until taken, otherwise idle in bursts or issue the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && n_accepted != n_issued) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_cmds.size() != 0) begin
			if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
				gap_left <= $urandom_range(0, 14);
				start <= 1'b0;
			end else begin
				req <= pending_cmds.pop_front();
				start <= 1'b1;
				n_issued++;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: predict on accept, check every strobed word
	always @(posedge clk) begin : monitor
		rsp_t want;
		logic took;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				apply_command(req);
				cmd_seen[req.command]++;
				n_accepted <= n_accepted + 1;
			end
			if (rsp_strobe) begin
				if (expected_updates.size() == 0) begin
					$display("%0t: unexpected word: expected none, got %p", $time, rsp);
					errors++;
				end else begin
					want = expected_updates.pop_front();
					check_field("shift_data_pin", {7'b0, want.shift_data_pin},
						{7'b0, rsp.shift_data_pin});
					check_field("delay_clock_pin", {7'b0, want.delay_clock_pin},
						{7'b0, rsp.delay_clock_pin});
					check_field("mux_clock_pin", {7'b0, want.mux_clock_pin},
						{7'b0, rsp.mux_clock_pin});
					check_field("strobe_pins", want.strobe_pins, rsp.strobe_pins);
					check_field("read_value", want.read_value, rsp.read_value);
					check_field("last_update", {7'b0, want.last_update},
						{7'b0, rsp.last_update});
					words_checked++;
				end
			end
			stall_cycles <= took ? 0 : stall_cycles + 1;
		end
	end

	initial begin
		logic timed_out;
		timed_out = 1'b0;

		// reset state reads, then extremes and every field
		queue_cmd(CMD_GET_DELAY, 3'd0, 8'h5a);
		queue_cmd(CMD_GET_MUX, 3'd3, 8'h00);
		queue_cmd(CMD_SET_DELAY, 3'd0, 8'hff);
		queue_cmd(CMD_SET_DELAY, 3'd7, 8'h00);
		queue_cmd(CMD_SET_DELAY, 3'd3, 8'ha5);
		queue_cmd(CMD_SET_DELAY, 3'd4, 8'h5a);
		queue_cmd(CMD_GET_DELAY, 3'd0, 8'h00);
		queue_cmd(CMD_GET_DELAY, 3'd7, 8'hff);
		queue_cmd(CMD_GET_DELAY, 3'd3, 8'h00);
		queue_cmd(CMD_GET_DELAY, 3'd4, 8'h00);
		// upper bits of the field value must be dropped
		queue_cmd(CMD_SET_MUX, 3'd0, 8'hff);
		queue_cmd(CMD_SET_MUX, 3'd1, 8'hfc);
		queue_cmd(CMD_SET_MUX, 3'd2, 8'h02);
		queue_cmd(CMD_SET_MUX, 3'd3, 8'h01);
		queue_cmd(CMD_GET_MUX, 3'd0, 8'h00);
		queue_cmd(CMD_GET_MUX, 3'd1, 8'h00);
		queue_cmd(CMD_GET_MUX, 3'd2, 8'h00);
		queue_cmd(CMD_GET_MUX, 3'd3, 8'h00);
		// mux fields past the last one: ignored write, zero read
		queue_cmd(CMD_SET_MUX, 3'd4, 8'hff);
		queue_cmd(CMD_SET_MUX, 3'd7, 8'h03);
		queue_cmd(CMD_GET_MUX, 3'd5, 8'hff);
		queue_cmd(CMD_GET_MUX, 3'd7, 8'h00);
		queue_cmd(CMD_SET_MUX, 3'd3, 8'h00);
		queue_cmd(CMD_GET_MUX, 3'd3, 8'h00);
		for (int i = 0; i < 336; i++)
			pending_cmds.push_back(random_cmd());

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || n_accepted != n_issued
				|| expected_updates.size() != 0) begin
			@(negedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end

		if (timed_out) begin
			$display("%0t: no progress for %0d cycles, %0d words still owed",
				$time, STALL_LIMIT, expected_updates.size());
			$display("TB_ERROR");
		end else begin
			// catch any stray words after the last expected one
			repeat (DRAIN_CYCLES) @(negedge clk);
			$display("Commands: %0d delay writes, %0d delay reads, %0d mux writes, %0d mux reads",
				cmd_seen[CMD_SET_DELAY], cmd_seen[CMD_GET_DELAY],
				cmd_seen[CMD_SET_MUX], cmd_seen[CMD_GET_MUX]);
			$display("Pin update words checked: %0d, errors: %0d", words_checked, errors);
			if (errors == 0)
				$display("TB_OK");
			else
				$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/srcl_pkg.sv
hdl/srcl_front.sv
hdl/srcl_queue.sv
hdl/srcl_back.sv
hdl/shift_register_config_loader.sv
dv/shift_register_config_loader_test.sv
